FILE: hw/rtl/pesd_pkg.sv
// Shared types, constants and event decode function for the pattern event stream decoder.
`default_nettype none

package pesd_pkg;

  // Geometry of the pattern section
  localparam int ROWS_PER_PATTERN = 64;   // 1..64
  localparam int CHANNELS         = 9;    // 1..16
  localparam int PATTERN_COUNT    = 128;  // 1..128

  localparam int ROW_W = (ROWS_PER_PATTERN > 1) ? $clog2(ROWS_PER_PATTERN) : 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Byte layout
  localparam logic [7:0] NOTE_FX_FLAG = 8'h80;  // note byte carries an effect byte
  localparam logic [3:0] SEMI_KEY_OFF = 4'd15;
  localparam logic [3:0] SEMI_MAX     = 4'd12;
  localparam logic [6:0] SEMIS_PER_OCT = 7'd12;

  // Effect groups, taken from fx[7:5]
  localparam logic [2:0] FXG_INSTR  = 3'd1;
  localparam logic [2:0] FXG_VOLUME = 3'd2;
  localparam logic [2:0] FXG_SPEED  = 3'd3;
  localparam logic [2:0] FXG_SLIDE_UP = 3'd4;
  localparam logic [2:0] FXG_SLIDE_DN = 3'd5;
  localparam logic [2:0] FXG_BREAK  = 3'd7;

  // Reported effect kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_VOLUME   = 3'd1;
  localparam logic [2:0] KIND_SPEED    = 3'd2;
  localparam logic [2:0] KIND_SLIDE_UP = 3'd3;
  localparam logic [2:0] KIND_SLIDE_DN = 3'd4;
  localparam logic [2:0] KIND_BREAK    = 3'd5;

  typedef enum logic [1:0] {
    ST_EVENT  = 2'd0,
    ST_CLEAN  = 2'd1,
    ST_FORMAT = 2'd2,
    ST_EOD    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_NUMBER = 3'b001,
    PH_NOTE   = 3'b010,
    PH_EFFECT = 3'b100
  } phase_t;

  // Decoded musical content of one event
  typedef struct packed {
    logic [5:0] effect_value;
    logic [2:0] effect_kind;
    logic [5:0] instrument;
    logic       key_off;
    logic [6:0] pitch;
  } evt_t;

  function automatic evt_t decode_event(input logic [6:0] note, input logic [7:0] fx);
    evt_t       e;
    logic [3:0] semi;
    logic [2:0] oct;
    logic [4:0] low;
    semi = note[3:0];
    oct  = note[6:4];
    low  = fx[4:0];
    e    = '0;
    if (semi != 4'd0 && semi <= SEMI_MAX) begin
      e.pitch = 7'(semi) + (7'(oct) * SEMIS_PER_OCT);
    end else if (semi == SEMI_KEY_OFF) begin
      e.key_off = 1'b1;
    end
    case (fx[7:5])
      FXG_INSTR: begin
        e.instrument = 6'(low) + 6'd1;
      end
      FXG_VOLUME: begin
        e.effect_kind  = KIND_VOLUME;
        e.effect_value = {low, 1'b0};
      end
      FXG_SPEED: begin
        e.effect_kind  = KIND_SPEED;
        e.effect_value = 6'(low) + 6'd1;
      end
      FXG_SLIDE_UP: begin
        e.effect_kind  = KIND_SLIDE_UP;
        e.effect_value = 6'(low);
      end
      FXG_SLIDE_DN: begin
        e.effect_kind  = KIND_SLIDE_DN;
        e.effect_value = 6'(low);
      end
      FXG_BREAK: begin
        e.effect_kind = KIND_BREAK;
      end
      default: begin
        e.effect_kind = KIND_NONE;
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pattern_event_stream_decoder.sv
// Pattern event stream decoder: byte parser, event decode and output register.
//
// Takes the pattern section of a song one byte per transaction on the s_ side
// and delivers one decoded note event per completed event on the m_ side.
// Each pattern is a pattern-number byte followed by ROWS_PER_PATTERN x
// CHANNELS events (channel fastest); an event is a note byte, plus an effect
// byte when bit 7 of the note byte is set. Pattern numbers must rise strictly
// and stay below PATTERN_COUNT, else a format-error result (status 2) is sent.
// A section cut short sends status 3; the last event of a pattern on a byte
// marked tlast sends status 1 and the decoder returns to its reset state for
// the next section. After status 2 or 3 the decoder swallows every byte with
// no result until rst. Throughput is one byte per clock: the parse and decode
// are a short combinational path in front of a single output register, and
// s_tready stays high unless that register holds a result the sink has not
// taken.
// A result appears on m_ in the cycle after the byte that completes it is accepted.
`default_nettype none

module pattern_event_stream_decoder
  import pesd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // stream_last
  // decoded events
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [6:0] pattern_number, [12:7] row,
                                      // [16:13] channel, [23:17] pitch,
                                      // [24] key_off, [30:25] instrument,
                                      // [33:31] effect_kind, [39:34] effect_value
  output logic [1:0]       m_tuser    // [1:0] status
);

  typedef struct packed {
    evt_t       evt;
    logic [3:0] channel;
    logic [5:0] row;
    logic [6:0] pattern_number;
  } res_t;

  // Parser state
  phase_t           phase, phase_next;
  logic [7:0]       prior_pattern, prior_pattern_next;
  logic             prior_valid, prior_valid_next;
  logic [6:0]       current_pattern, current_pattern_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [CH_W-1:0]  channel_count, channel_count_next;
  logic [6:0]       held_note, held_note_next;
  logic             halted, halted_next;

  // Output register
  res_t    result, result_next;
  status_t status, status_next;
  logic    emit;

  logic       accept;
  logic       bad_number;
  logic       ch_last, row_last;
  logic [6:0] ev_note;
  logic [7:0] ev_fx;
  evt_t       evt;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign bad_number = (prior_valid && (prior_pattern >= s_tdata)) ||
                      ({1'b0, s_tdata} >= 9'(PATTERN_COUNT));
  assign ch_last    = (channel_count == CH_W'(CHANNELS - 1));
  assign row_last   = (row_count == ROW_W'(ROWS_PER_PATTERN - 1));

  // Event source: held note with this byte as effect, or this byte as a bare note
  assign ev_note = (phase == PH_EFFECT) ? held_note : s_tdata[6:0];
  assign ev_fx   = (phase == PH_EFFECT) ? s_tdata : 8'h00;
  assign evt     = decode_event(ev_note, ev_fx);

  always_comb begin
    phase_next           = phase;
    prior_pattern_next   = prior_pattern;
    prior_valid_next     = prior_valid;
    current_pattern_next = current_pattern;
    row_count_next       = row_count;
    channel_count_next   = channel_count;
    held_note_next       = held_note;
    halted_next          = halted;
    emit                 = 1'b0;
    result_next          = '0;
    status_next          = ST_EVENT;

    if (accept && !halted) begin
      case (phase)
        PH_NUMBER: begin
          if (bad_number) begin
            emit        = 1'b1;
            status_next = ST_FORMAT;
            halted_next = 1'b1;
          end else begin
            prior_pattern_next   = s_tdata;
            prior_valid_next     = 1'b1;
            current_pattern_next = s_tdata[6:0];
            row_count_next       = '0;
            channel_count_next   = '0;
            if (s_tlast) begin
              emit        = 1'b1;
              status_next = ST_EOD;
              halted_next = 1'b1;
            end else begin
              phase_next = PH_NOTE;
            end
          end
        end
        PH_NOTE, PH_EFFECT: begin
          if (phase == PH_NOTE && (s_tdata & NOTE_FX_FLAG) != 8'h00) begin
            held_note_next = s_tdata[6:0];
            if (s_tlast) begin
              emit        = 1'b1;
              status_next = ST_EOD;
              halted_next = 1'b1;
            end else begin
              phase_next = PH_EFFECT;
            end
          end else begin
            // completed event
            emit                       = 1'b1;
            result_next.evt            = evt;
            result_next.pattern_number = current_pattern;
            result_next.row            = 6'(row_count);
            result_next.channel        = 4'(channel_count);
            if (s_tlast) begin
              if (ch_last && row_last) begin
                // clean end of section: back to reset state
                status_next          = ST_CLEAN;
                phase_next           = PH_NUMBER;
                prior_pattern_next   = '0;
                prior_valid_next     = 1'b0;
                current_pattern_next = '0;
                row_count_next       = '0;
                channel_count_next   = '0;
                held_note_next       = '0;
                halted_next          = 1'b0;
              end else begin
                status_next = ST_EOD;
                halted_next = 1'b1;
              end
            end else begin
              status_next = ST_EVENT;
              phase_next  = PH_NOTE;
              if (ch_last) begin
                channel_count_next = '0;
                if (row_last) begin
                  row_count_next = '0;
                  phase_next     = PH_NUMBER;
                end else begin
                  row_count_next = row_count + ROW_W'(1);
                end
              end else begin
                channel_count_next = channel_count + CH_W'(1);
              end
            end
          end
        end
        default: begin
          phase_next = PH_NUMBER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_NUMBER;
      prior_pattern   <= '0;
      prior_valid     <= 1'b0;
      current_pattern <= '0;
      row_count       <= '0;
      channel_count   <= '0;
      held_note       <= '0;
      halted          <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      phase           <= phase_next;
      prior_pattern   <= prior_pattern_next;
      prior_valid     <= prior_valid_next;
      current_pattern <= current_pattern_next;
      row_count       <= row_count_next;
      channel_count   <= channel_count_next;
      held_note       <= held_note_next;
      halted          <= halted_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
      status <= status_next;
    end
  end

  assign m_tdata = result;
  assign m_tuser = status;

  // A halted decoder never produces another result
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (halted && m_tvalid && m_tready) |=> !m_tvalid)
    else $error("result produced while halted");

  // Error results always leave the decoder halted
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_FORMAT || m_tuser == ST_EOD)) |-> halted)
    else $error("error status without halt");

  // A clean end leaves the parser in its reset state
  a_clean_resets: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_CLEAN) |->
      (phase == PH_NUMBER && !prior_valid && !halted))
    else $error("clean end did not restart parser");

  // A note byte without an effect flag always yields a result
  a_note_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && !halted && phase == PH_NOTE && !s_tdata[7]) |=> m_tvalid)
    else $error("completed event lost");

  // Channel counter wraps after the last channel of a completed event
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (accept && ch_last && !halted &&
     (phase == PH_EFFECT || (phase == PH_NOTE && !s_tdata[7]))) |=>
      (channel_count == '0 || halted))
    else $error("channel counter overran");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the pattern event stream decoder.
`timescale 1ns / 100ps

module tb_top
  import pesd_pkg::*;
();

  localparam int EVENTS_PER_PATTERN = ROWS_PER_PATTERN * CHANNELS;
  localparam int MAX_REPORTS        = 10;

  // One decoded event as seen on m_tdata / m_tuser
  typedef struct packed {
    logic [6:0] pattern_number;
    logic [5:0] row;
    logic [3:0] channel;
    logic [6:0] pitch;
    logic       key_off;
    logic [5:0] instrument;
    logic [2:0] effect_kind;
    logic [5:0] effect_value;
    status_t    status;
  } note_event_t;

  // How the second section of the run is broken off
  typedef enum int {
    FAULT_BAD_NUMBER,
    FAULT_END_AFTER_NUMBER,
    FAULT_END_AFTER_FLAG,
    FAULT_END_MID_PATTERN,
    FAULT_NOT_RISING
  } fault_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
  logic        s_tlast  = 1'b0; // stream_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // pattern_number, row, channel, pitch, key_off,
                                // instrument, effect_kind, effect_value
  logic [1:0]  m_tuser;         // [1:0] status

  always #2 clk = ~clk;

  pattern_event_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Parser tracker: own copy of the decoder state, advanced per accepted byte
  // ---------------------------------------------------------------------------
  phase_t      trk_phase;
  int          trk_prior;
  bit          trk_prior_seen;
  int          trk_pattern;
  int          trk_row;
  int          trk_chan;
  logic [6:0]  trk_note;
  bit          trk_halted;

  note_event_t expected_events[$];
  int          fail_count;

  bit          src_calm;
  bit          sink_calm;
  int          sink_hold;

  task automatic clear_tracker();
    trk_phase      = PH_NUMBER;
    trk_prior      = 0;
    trk_prior_seen = 1'b0;
    trk_pattern    = 0;
    trk_row        = 0;
    trk_chan       = 0;
    trk_note       = '0;
    trk_halted     = 1'b0;
  endtask

  function automatic note_event_t status_only(input status_t st);
    note_event_t e;
    e        = '0;
    e.status = st;
    return e;
  endfunction

  // Musical fields of a completed event at the tracked position
  function automatic note_event_t expected_event(input logic [6:0] note,
                                                 input logic [7:0] fx,
                                                 input status_t st);
    note_event_t e;
    logic [3:0]  semi;
    logic [4:0]  arg;
    e    = '0;
    semi = note[3:0];
    arg  = fx[4:0];
    e.pattern_number = 7'(trk_pattern);
    e.row            = 6'(trk_row);
    e.channel        = 4'(trk_chan);
    e.status         = st;
    if (semi >= 4'd1 && semi <= SEMI_MAX) begin
      e.pitch = 7'(semi) + 7'(note[6:4]) * SEMIS_PER_OCT;
    end else if (semi == SEMI_KEY_OFF) begin
      e.key_off = 1'b1;
    end
    // groups 0 and 6 carry nothing
    case (fx[7:5])
      FXG_INSTR: begin
        e.instrument = 6'(arg) + 6'd1;
      end
      FXG_VOLUME: begin
        e.effect_kind  = KIND_VOLUME;
        e.effect_value = 6'(arg) << 1;
      end
      FXG_SPEED: begin
        e.effect_kind  = KIND_SPEED;
        e.effect_value = 6'(arg) + 6'd1;
      end
      FXG_SLIDE_UP: begin
        e.effect_kind  = KIND_SLIDE_UP;
        e.effect_value = 6'(arg);
      end
      FXG_SLIDE_DN: begin
        e.effect_kind  = KIND_SLIDE_DN;
        e.effect_value = 6'(arg);
      end
      FXG_BREAK: begin
        e.effect_kind = KIND_BREAK;
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  task automatic close_event(input logic [6:0] note, input logic [7:0] fx, input bit last);
    bit pattern_done;
    pattern_done = (trk_chan == CHANNELS - 1) && (trk_row == ROWS_PER_PATTERN - 1);
    if (last) begin
      if (pattern_done) begin
        // clean end of section: decoder starts over as after reset
        expected_events.push_back(expected_event(note, fx, ST_CLEAN));
        clear_tracker();
      end else begin
        expected_events.push_back(expected_event(note, fx, ST_EOD));
        trk_halted = 1'b1;
      end
    end else begin
      expected_events.push_back(expected_event(note, fx, ST_EVENT));
      trk_phase = PH_NOTE;
      trk_chan++;
      if (trk_chan == CHANNELS) begin
        trk_chan = 0;
        trk_row++;
        if (trk_row == ROWS_PER_PATTERN) begin
          trk_row   = 0;
          trk_phase = PH_NUMBER;
        end
      end
    end
  endtask

  task automatic advance_tracker(input logic [7:0] b, input bit last);
    if (trk_halted) return;
    case (trk_phase)
      PH_NUMBER: begin
        if ((trk_prior_seen && trk_prior >= b) || b >= PATTERN_COUNT) begin
          expected_events.push_back(status_only(ST_FORMAT));
          trk_halted = 1'b1;
        end else begin
          trk_prior      = b;
          trk_prior_seen = 1'b1;
          trk_pattern    = b;
          trk_row        = 0;
          trk_chan       = 0;
          if (last) begin
            expected_events.push_back(status_only(ST_EOD));
            trk_halted = 1'b1;
          end else begin
            trk_phase = PH_NOTE;
          end
        end
      end
      PH_NOTE: begin
        if ((b & NOTE_FX_FLAG) != 0) begin
          trk_note = b[6:0];
          if (last) begin
            expected_events.push_back(status_only(ST_EOD));
            trk_halted = 1'b1;
          end else begin
            trk_phase = PH_EFFECT;
          end
        end else begin
          close_event(b[6:0], 8'h00, last);
        end
      end
      default: begin
        close_event(trk_note, b, last);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Idle pattern shared by source and sink
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sink: random backpressure with quiet stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 127) == 0) sink_calm = !sink_calm;
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      sink_hold = pick_gap(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic string show_event(input note_event_t e);
    return $sformatf({"pat=%0d row=%0d ch=%0d pitch=%0d koff=%0d ",
                      "instr=%0d kind=%0d val=%0d st=%0d"},
                     e.pattern_number, e.row, e.channel, e.pitch, e.key_off,
                     e.instrument, e.effect_kind, e.effect_value, e.status);
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    note_event_t got;
    note_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.pattern_number = m_tdata[6:0];
      got.row            = m_tdata[12:7];
      got.channel        = m_tdata[16:13];
      got.pitch          = m_tdata[23:17];
      got.key_off        = m_tdata[24];
      got.instrument     = m_tdata[30:25];
      got.effect_kind    = m_tdata[33:31];
      got.effect_value   = m_tdata[39:34];
      got.status         = status_t'(m_tuser);
      if (expected_events.size() == 0) begin
        log_failure({"unexpected transaction: ", show_event(got)});
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          log_failure({"expected ", show_event(want), " got ", show_event(got)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  // Valid stays high after a transaction; it drops only for a gap, so it is
  // never lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_tracker(b, last);
  endtask

  // Note byte, plus effect byte when bit 7 of the note byte is set
  task automatic send_event(input logic [7:0] note_b, input logic [7:0] fx, input bit last);
    if ((note_b & NOTE_FX_FLAG) != 0) begin
      send_byte(note_b, 1'b0);
      send_byte(fx, last);
    end else begin
      send_byte(note_b, last);
    end
  endtask

  // Effect bytes kept rare here so a full pattern stays near one byte per event
  task automatic send_random_events(input int count, input bit mark_last);
    logic [7:0] note_b;
    for (int i = 0; i < count; i++) begin
      note_b    = 8'($urandom_range(0, 255));
      note_b[7] = ($urandom_range(0, 99) < 12);
      send_event(note_b, 8'($urandom_range(0, 255)), mark_last && (i == count - 1));
    end
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  int n_directed;

  // Pattern 0, then note/effect corners: semitones 0-3, 5, 7, 10 and 12-15, octave 7,
  // every effect group with its smallest or largest argument, most with both.
  task automatic test_event_decode();
    logic [15:0] evs [15];
    evs = '{16'h00_00, 16'h81_00, 16'hFC_20, 16'h8D_3F, 16'h8E_40, 16'hFE_5F,
            16'hF1_60, 16'hCC_7F, 16'hB5_80, 16'hFF_9F, 16'hDA_BF, 16'hC3_C0,
            16'h92_DF, 16'h97_E0, 16'hF0_FF};
    send_byte(8'd0, 1'b0);
    foreach (evs[i]) send_event(evs[i][15:8], evs[i][7:0], 1'b0);
    n_directed = $size(evs);
  endtask

  // Rest of pattern 0 with random content; the final event carries tlast.
  // Partway through, the source waits for the sink to catch up.
  task automatic test_full_pattern_clean_end();
    send_random_events(200, 1'b0);
    hold_until_drained();
    send_random_events(EVENTS_PER_PATTERN - n_directed - 200, 1'b1);
    hold_until_drained();
  endtask

  // New section, broken off in one of the error ways
  task automatic test_section_fault();
    fault_t pick;
    int     pat;
    int     lead;
    pick = fault_t'($urandom_range(0, 4));
    pat  = $urandom_range(0, PATTERN_COUNT - 1);
    lead = $urandom_range(0, 3 * CHANNELS);
    case (pick)
      FAULT_BAD_NUMBER: begin
        send_byte(8'($urandom_range(PATTERN_COUNT, 255)), 1'($urandom_range(0, 1)));
      end
      FAULT_END_AFTER_NUMBER: begin
        send_byte(8'(PATTERN_COUNT - 1), 1'b1);
      end
      FAULT_END_AFTER_FLAG: begin
        send_byte(8'(pat), 1'b0);
        send_random_events(lead, 1'b0);
        send_byte(NOTE_FX_FLAG | 8'($urandom_range(0, 127)), 1'b1);
      end
      FAULT_END_MID_PATTERN: begin
        send_byte(8'(pat), 1'b0);
        send_random_events(lead + 1, 1'b1);
      end
      default: begin
        // full pattern without tlast, then a number that does not rise
        send_byte(8'(pat), 1'b0);
        send_random_events(EVENTS_PER_PATTERN, 1'b0);
        send_byte(8'($urandom_range(0, pat)), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // Once halted, everything is swallowed without a result
  task automatic test_halted_bytes();
    for (int i = 0; i < 16; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clear_tracker();
    fail_count = 0;
    src_calm   = 1'b0;
    sink_calm  = 1'b0;
    sink_hold  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_event_decode();
    test_full_pattern_clean_end();
    test_section_fault();
    test_halted_bytes();

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
